FILE: hw/rtl/bnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, constants and helpers of the 3x3 binary neighborhood counter.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int WIDTH_LIM  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_LIM = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] CFG_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] CFG_HEIGHT_RST = 11'd1024;

  // result kinds of one item, in delivery order
  localparam int RES_UP_PREV  = 0;  // row above, previous column
  localparam int RES_UP_CUR   = 1;  // row above, this column at row end
  localparam int RES_LAST_PREV = 2; // last row, previous column
  localparam int RES_LAST_CUR = 3;  // last row, this column at row end
  localparam int RES_N        = 4;

  localparam logic [8:0] MASK_FULL      = 9'h1FF;
  localparam logic [8:0] MASK_RIGHT     = 9'h1F8;
  localparam logic [8:0] MASK_BOTTOM    = 9'h1B6;
  localparam logic [8:0] MASK_BOT_RIGHT = 9'h1B0;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_t;

  function automatic logic [COUNT_W-1:0] bnc_popcount(input logic [8:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + COUNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/bnc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/binary_neighborhood_count_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_neighborhood_count_3x3
// Streams a binary image in raster order and reports, per pixel, the number
// of set pixels in its 3x3 neighborhood with its row and column.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o   pixel_i
//   out      out  out_valid_o/out_stall_i count_o row_o column_o run_end_o
//                                         image_end_o
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// One pixel is taken per cycle unless in_stall_o is high; results leave one
// per cycle through the output register unless out_stall_i is high, so a
// row end yields up to 2 results, a last-row pixel up to 2 and an image's
// final pixel up to 4. A pixel passes the read stage and the result bundle.
// Both line buffers share one 2-bit RAM, read at accept and written when the
// pixel leaves the read stage, with a bypass when the same column is read and
// written together.
// Reset needs no clearing pass. A stalled output holds; the input stalls only
// when the pending results of the previous pixel cannot drain.
// ----------------------------------------------------------------------------
module binary_neighborhood_count_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bnc_pkg::COUNT_W-1:0]     count_o,
  output logic [bnc_pkg::CNT_W-1:0]       row_o,
  output logic [bnc_pkg::CNT_W-1:0]       column_o,
  output logic                            run_end_o,
  output logic                            image_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bnc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bnc_pkg::CFG_W-1:0]       cfg_data_i
);
  import bnc_pkg::*;

  localparam logic [CFG_W-1:0] WLIM = CFG_W'(WIDTH_LIM);
  localparam logic [CFG_W-1:0] HLIM = CFG_W'(HEIGHT_LIM);

  // configuration
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_WIDTH_RST;
      cfg_height_q <= CFG_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_WIDTH) begin
        cfg_width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_IDX_HEIGHT) begin
        cfg_height_q <= cfg_data_i;
      end
    end
  end

  // position counters and clamping
  logic [CNT_W-1:0] row_cnt_q, row_cnt_d, col_cnt_q, col_cnt_d;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] w_last, h_last, c_eff, r_eff;
  logic             row_end, last_row;
  logic             in_accept;

  always_comb begin
    w_eff = cfg_width_q;
    if (w_eff == '0) begin
      w_eff = CFG_W'(1);
    end else if (w_eff > WLIM) begin
      w_eff = WLIM;
    end
    h_eff = cfg_height_q;
    if (h_eff == '0) begin
      h_eff = CFG_W'(1);
    end else if (h_eff > HLIM) begin
      h_eff = HLIM;
    end
    w_last   = CNT_W'(w_eff - CFG_W'(1));
    h_last   = CNT_W'(h_eff - CFG_W'(1));
    c_eff    = (col_cnt_q > w_last) ? w_last : col_cnt_q;
    r_eff    = (row_cnt_q > h_last) ? h_last : row_cnt_q;
    row_end  = (c_eff == w_last);
    last_row = (r_eff == h_last);
    if (row_end) begin
      col_cnt_d = '0;
      row_cnt_d = last_row ? '0 : r_eff + CNT_W'(1);
    end else begin
      col_cnt_d = c_eff + CNT_W'(1);
      row_cnt_d = r_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (in_accept) begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
    end
  end

  // read stage
  logic             s1_valid_q, s1_pix_q, s1_row_end_q, s1_last_q, s1_fwd_q;
  logic [CNT_W-1:0] s1_r_q, s1_c_q;
  line_t            s1_fwd_data_q;
  logic             s1_consume;
  line_t            ram_rdata, rd_eff, ram_wdata;
  logic             up_bit, mid_bit;

  // result bundle and output register
  logic [RES_N-1:0] bnd_pend_q, bnd_pend_new, bnd_pick, bnd_pend_after;
  logic [8:0]       bnd_win_q, win_new;
  logic [CNT_W-1:0] bnd_r_q, bnd_c_q;
  logic             bnd_img_end_q;
  logic             bundle_free, emit;
  logic             out_valid_q, out_take;
  logic [COUNT_W-1:0] out_count_q;
  logic [CNT_W-1:0]   out_row_q, out_col_q;
  logic               out_run_end_q, out_img_end_q;
  logic [8:0]         emit_mask;
  logic [CNT_W-1:0]   emit_row, emit_col;

  assign out_take    = out_valid_q && !out_stall_i;
  assign emit        = (bnd_pend_q != '0) && (!out_valid_q || out_take);
  assign bundle_free = (bnd_pend_q == '0) || (emit && (bnd_pend_after == '0));
  assign s1_consume  = s1_valid_q && bundle_free;
  assign in_stall_o  = s1_valid_q && !bundle_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  bnc_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_consume),
    .waddr_i (ADDR_W'(s1_c_q)),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (ADDR_W'(c_eff)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_consume);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q      <= pixel_i;
      s1_r_q        <= r_eff;
      s1_c_q        <= c_eff;
      s1_row_end_q  <= row_end;
      s1_last_q     <= last_row;
      s1_fwd_q      <= s1_consume && (s1_c_q == c_eff);
      s1_fwd_data_q <= ram_wdata;
    end
  end

  always_comb begin
    rd_eff           = s1_fwd_q ? s1_fwd_data_q : ram_rdata;
    ram_wdata.upper  = rd_eff.middle;
    ram_wdata.middle = s1_pix_q;
    up_bit  = (s1_r_q >= CNT_W'(2)) ? rd_eff.upper : 1'b0;
    mid_bit = (s1_r_q != '0) ? rd_eff.middle : 1'b0;
    if (s1_c_q == '0) begin
      win_new = {s1_pix_q, mid_bit, up_bit, 6'b0};
    end else begin
      win_new = {s1_pix_q, mid_bit, up_bit, bnd_win_q[8:3]};
    end
    bnd_pend_new                = '0;
    bnd_pend_new[RES_UP_PREV]   = (s1_r_q != '0) && (s1_c_q != '0);
    bnd_pend_new[RES_UP_CUR]    = (s1_r_q != '0) && s1_row_end_q;
    bnd_pend_new[RES_LAST_PREV] = s1_last_q && (s1_c_q != '0);
    bnd_pend_new[RES_LAST_CUR]  = s1_last_q && s1_row_end_q;
  end

  // lowest pending result goes first
  always_comb begin
    bnd_pick = '0;
    if (bnd_pend_q[RES_UP_PREV]) begin
      bnd_pick[RES_UP_PREV] = 1'b1;
    end else if (bnd_pend_q[RES_UP_CUR]) begin
      bnd_pick[RES_UP_CUR] = 1'b1;
    end else if (bnd_pend_q[RES_LAST_PREV]) begin
      bnd_pick[RES_LAST_PREV] = 1'b1;
    end else begin
      bnd_pick[RES_LAST_CUR] = 1'b1;
    end
    bnd_pend_after = bnd_pend_q & ~bnd_pick;
    emit_mask = ({9{bnd_pick[RES_UP_PREV]}}   & MASK_FULL)
              | ({9{bnd_pick[RES_UP_CUR]}}    & MASK_RIGHT)
              | ({9{bnd_pick[RES_LAST_PREV]}} & MASK_BOTTOM)
              | ({9{bnd_pick[RES_LAST_CUR]}}  & MASK_BOT_RIGHT);
    emit_row = (bnd_pick[RES_UP_PREV] || bnd_pick[RES_UP_CUR])
             ? bnd_r_q - CNT_W'(1) : bnd_r_q;
    emit_col = (bnd_pick[RES_UP_PREV] || bnd_pick[RES_LAST_PREV])
             ? bnd_c_q - CNT_W'(1) : bnd_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_pend_q <= '0;
      bnd_win_q  <= '0;
    end else if (s1_consume) begin
      bnd_pend_q <= bnd_pend_new;
      bnd_win_q  <= win_new;
    end else if (emit) begin
      bnd_pend_q <= bnd_pend_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_consume) begin
      bnd_r_q       <= s1_r_q;
      bnd_c_q       <= s1_c_q;
      bnd_img_end_q <= s1_last_q && s1_row_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_count_q   <= bnc_popcount(bnd_win_q & emit_mask);
      out_row_q     <= emit_row;
      out_col_q     <= emit_col;
      out_run_end_q <= (bnd_pend_after == '0);
      out_img_end_q <= (bnd_pend_after == '0) && bnd_img_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = out_count_q;
  assign row_o       = out_row_q;
  assign column_o    = out_col_q;
  assign run_end_o   = out_run_end_q;
  assign image_end_o = out_img_end_q;

endmodule

FILE: hw/rtl/bnc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_checker
// Port-level checks of the 3x3 neighborhood counter, bound to the top level.
// ----------------------------------------------------------------------------
module bnc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [bnc_pkg::COUNT_W-1:0] count_i,
  input logic [bnc_pkg::CNT_W-1:0]   row_i,
  input logic [bnc_pkg::CNT_W-1:0]   column_i,
  input logic                        run_end_i,
  input logic                        image_end_i
);
  import bnc_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(count_i)
      && $stable(row_i) && $stable(column_i) && $stable(run_end_i)
      && $stable(image_end_i))
    else $error("output item changed under stall");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= COUNT_W'(9))
    else $error("count out of range");

  a_image_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && image_end_i |-> run_end_i)
    else $error("image end without run end");

  // results of one pixel leave without gaps
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !run_end_i |=> out_valid_i)
    else $error("gap inside the results of one item");

endmodule

bind binary_neighborhood_count_3x3 bnc_checker u_bnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .count_i     (count_o),
  .row_i       (row_o),
  .column_i    (column_o),
  .run_end_i   (run_end_o),
  .image_end_i (image_end_o)
);

FILE: test/binary_neighborhood_count_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_neighborhood_count_3x3_tb
// Streams binary images through the 3x3 neighborhood counter. The scoreboard
// tracks its own line buffers, window and raster position, and predicts every
// count with its row, column and end flags. Each accepted count is checked
// against the oldest prediction. Covered: tiny and single-pixel images,
// size registers out of range, size changes in the middle of an
// image, random idle and stall bursts, and a long output stall.
// ----------------------------------------------------------------------------
module binary_neighborhood_count_3x3_tb;
  import bnc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          LONG_HOLD   = 300;
  localparam int          SETTLE      = 8;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CNT_W-1:0]   row;
    logic [CNT_W-1:0]   column;
    logic               run_end;
    logic               image_end;
  } nbhd_count_t;

  class nbhd_scoreboard;
    bit                 upper_row [MAX_WIDTH];
    bit                 middle_row [MAX_WIDTH];
    logic [8:0]         win;
    int                 row_q;
    int                 col_q;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    nbhd_count_t        expected_q[$];
    int                 mismatches;
    int                 counts_checked;
    int                 pixels_seen;
    int                 images_done;

    function new();
      win        = '0;
      row_q      = 0;
      col_q      = 0;
      width_reg  = CFG_WIDTH_RST;
      height_reg = CFG_HEIGHT_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_IDX_WIDTH) begin
        width_reg = val;
      end else if (idx == CFG_IDX_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    // effective size and position after clamping
    function void geometry(output int w, output int h, output int r, output int c);
      w = (width_reg == 0) ? 1 : ((width_reg > WIDTH_LIM) ? WIDTH_LIM : int'(width_reg));
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIM) ? HEIGHT_LIM : int'(height_reg));
      c = (col_q > w - 1) ? w - 1 : col_q;
      r = (row_q > h - 1) ? h - 1 : row_q;
    endfunction

    function int pixels_left();
      int w, h, r, c;
      geometry(w, h, r, c);
      return (h - 1 - r) * w + (w - c);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_count(logic [8:0] mask, int r, int c, inout nbhd_count_t batch[$]);
      nbhd_count_t res;
      res.count     = COUNT_W'($countones(win & mask));
      res.row       = CNT_W'(r);
      res.column    = CNT_W'(c);
      res.run_end   = 1'b0;
      res.image_end = 1'b0;
      batch.push_back(res);
    endfunction

    function void note_pixel(logic px);
      int          w, h, r, c;
      bit          up, mid, row_end, last_row;
      nbhd_count_t batch[$];
      geometry(w, h, r, c);
      row_end  = (c == w - 1);
      last_row = (r == h - 1);
      up  = (r >= 2) ? upper_row[c] : 1'b0;
      mid = (r >= 1) ? middle_row[c] : 1'b0;
      upper_row[c]  = middle_row[c];
      middle_row[c] = px;
      if (c == 0) begin
        win = {px, mid, up, 6'b0};
      end else begin
        win = {px, mid, up, win[8:3]};
      end
      if (r >= 1) begin
        if (c >= 1) add_count(MASK_FULL, r - 1, c - 1, batch);
        if (row_end) add_count(MASK_RIGHT, r - 1, c, batch);
      end
      // no row below the last one
      if (last_row) begin
        if (c >= 1) add_count(MASK_BOTTOM, r, c - 1, batch);
        if (row_end) add_count(MASK_BOT_RIGHT, r, c, batch);
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].run_end   = 1'b1;
        batch[batch.size() - 1].image_end = last_row && row_end;
      end
      foreach (batch[i]) expected_q.push_back(batch[i]);
      pixels_seen++;
      if (row_end) begin
        col_q = 0;
        row_q = last_row ? 0 : r + 1;
        if (last_row) images_done++;
      end else begin
        col_q = c + 1;
        row_q = r;
      end
    endfunction

    function void check_result(nbhd_count_t got);
      nbhd_count_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: count %0d row %0d column %0d run_end %b image_end %b",
                   got.count, got.row, got.column, got.run_end, got.image_end);
        end
        return;
      end
      exp_res = expected_q.pop_front();
      counts_checked++;
      if (got.count !== exp_res.count || got.row !== exp_res.row ||
          got.column !== exp_res.column || got.run_end !== exp_res.run_end ||
          got.image_end !== exp_res.image_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected count %0d row %0d column %0d run_end %b image_end %b",
                   exp_res.count, exp_res.row, exp_res.column, exp_res.run_end,
                   exp_res.image_end);
          $display("          got      count %0d row %0d column %0d run_end %b image_end %b",
                   got.count, got.row, got.column, got.run_end, got.image_end);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 pixel_i     = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [COUNT_W-1:0]   count_o;
  logic [CNT_W-1:0]     row_o;
  logic [CNT_W-1:0]     column_o;
  logic                 run_end_o;
  logic                 image_end_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  nbhd_scoreboard sb;
  bit             quiet         = 1'b0;
  bit             long_hold_req = 1'b0;
  int             idle_pct      = 0;
  int             stall_pct     = 0;
  int unsigned    cycle_count   = 0;

  binary_neighborhood_count_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .count_o    (count_o),
    .row_o      (row_o),
    .column_o   (column_o),
    .run_end_o  (run_end_o),
    .image_end_o(image_end_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    sb = new();
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // input noted before output so a same-edge order never matters
  always @(posedge clk_i) begin : monitor
    nbhd_count_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(pixel_i);
      if (out_valid_o && !out_stall_i) begin
        got.count     = count_o;
        got.row       = row_o;
        got.column    = column_o;
        got.run_end   = run_end_o;
        got.image_end = image_end_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && stall_pct != 0 &&
                   $urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic px);
    if (!quiet && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // density 0 gives all clear, 4 all set
  task automatic send_random(input int n, input int density);
    for (int i = 0; i < n; i++) send_pixel($urandom_range(0, 3) < density);
  endtask

  // step the clock first so the monitor has noted the last accepted pixel
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // sel picks register indexes; unused indexes get random data
  task automatic program_regs(input logic [3:0] sel, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    for (int k = 0; k < 2 ** CFG_IDX_W; k++) begin
      idx = CFG_IDX_W'(k);
      if (sel[k]) begin
        if (idx == CFG_IDX_WIDTH) begin
          val = w;
        end else if (idx == CFG_IDX_HEIGHT) begin
          val = h;
        end else begin
          val = CFG_W'($urandom);
        end
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i  <= val;
        do @(posedge clk_i); while (!cfg_ready_o);
        sb.write_reg(idx, val);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_idling();
    idle_pct  = 15 * $urandom_range(0, 2);
    stall_pct = 15 * $urandom_range(0, 2);
  endtask

  initial begin : stimulus
    int w, h, n, split, density, random_sent;
    random_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full window, single pixels, zero sizes, thin images
    idle_pct  = 20;
    stall_pct = 20;
    program_regs(4'b1111, 3, 3);
    send_random(9, 4);
    wait_drained();
    program_regs(4'b0011, 1, 1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    wait_drained();
    program_regs(4'b0011, 0, 0);
    send_pixel(1'b1);
    wait_drained();
    program_regs(4'b0011, 2, 1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    wait_drained();
    program_regs(4'b0011, 1, 3);
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    wait_drained();

    // width shrinks mid-image, current column lands past the new row end
    program_regs(4'b0011, 4, 3);
    send_random(6, 2);
    wait_drained();
    program_regs(4'b0001, 2, 0);
    send_random(sb.pixels_left(), 2);
    wait_drained();

    // height shrinks mid-image, current row becomes the last one
    program_regs(4'b0011, 3, 4);
    send_random(7, 3);
    wait_drained();
    program_regs(4'b0010, 0, 2);
    send_random(sb.pixels_left(), 3);
    wait_drained();

    // long output stall, input must back up
    program_regs(4'b0011, 8, 6);
    long_hold_req = 1'b1;
    send_random(sb.pixels_left(), 2);
    wait_drained();

    // out-of-range sizes clamp, then a shrink ends the image early
    pick_idling();
    program_regs(4'b0011, 2047, 0);
    send_random(5, $urandom_range(1, 3));
    wait_drained();
    program_regs(4'b0001, 6, 0);
    send_random(sb.pixels_left(), 2);
    wait_drained();
    pick_idling();
    program_regs(4'b0011, 0, 2047);
    send_random(3, $urandom_range(1, 3));
    wait_drained();
    program_regs(4'b0010, 0, 4);
    send_random(sb.pixels_left(), 2);
    wait_drained();

    while (random_sent < 90) begin
      w = $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) w = $urandom_range(9, 24);
      h = $urandom_range(1, 6);
      density = $urandom_range(0, 4);
      if (random_sent >= 60) quiet = 1'b1;
      pick_idling();
      program_regs(4'b0011, w, h);
      n = sb.pixels_left();
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
      for (int i = 0; i < n; i++) begin
        send_pixel($urandom_range(0, 3) < density);
        if (i + 1 == split) wait_drained();
      end
      random_sent += n;
      wait_drained();
    end

    $display("ran %0d pixels in %0d images, %0d counts checked", sb.pixels_seen,
             sb.images_done, sb.counts_checked);
    $display("sizes 1 to 1024 incl. zero and clamped values, mid-image resizes, long stall");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bnc_pkg.sv
hw/rtl/bnc_ram.sv
hw/rtl/binary_neighborhood_count_3x3.sv
hw/rtl/bnc_checker.sv
test/binary_neighborhood_count_3x3_tb.sv
